// ===== hw/rtl/drm_pkg.sv =====
// Package for the divider resistance measurement block.
// Holds error codes, register indexes and fixed output field widths.
// No dependencies.
package drm_pkg;

    localparam int MILLI_W = 10;
    localparam logic [MILLI_W-1:0] MILLI_PER_UNIT = 10'd1000;

    localparam int CODE_W = 3;
    localparam logic [CODE_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [CODE_W-1:0] ERR_REFERENCE = 3'd1;
    localparam logic [CODE_W-1:0] ERR_OPEN      = 3'd2;
    localparam logic [CODE_W-1:0] ERR_NEGATIVE  = 3'd3;
    localparam logic [CODE_W-1:0] ERR_OVERFLOW  = 3'd4;
    localparam logic [CODE_W-1:0] ERR_SHORT     = 3'd5;
    localparam logic [CODE_W-1:0] ERR_RANGE     = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_OHMS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINIMUM_OHMS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAXIMUM_OHMS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT_OHMS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_LIMIT_UV    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_OFFSET      = 3'd5;

    localparam int RES_W       = 34;
    localparam int VOLT_OUT_W  = 25;
    localparam int OUT_TDATA_W = 96;

endpackage

// ===== hw/rtl/drm_div_cell.sv =====
// One restoring division cell: produces one quotient bit per cycle while en is high.
// Standalone; chained by the top level.
module drm_div_cell #(
    parameter int VW = 24,
    parameter int PW = 58,
    parameter int SW = 54
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [VW-1:0] in_rem,
    input  logic [PW-1:0] in_dq,
    input  logic [VW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [VW-1:0] out_rem,
    output logic [PW-1:0] out_dq,
    output logic [VW-1:0] out_den,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [VW-1:0] rem_reg, rem_next;
    logic [PW-1:0] dq_reg, dq_next;
    logic [VW-1:0] den_reg;
    logic [SW-1:0] side_reg;
    logic [VW:0]   shifted;
    logic [VW:0]   trial;
    logic          ge;

    always_comb begin
        shifted  = {in_rem, in_dq[PW-1]};
        trial    = shifted - {1'b0, in_den};
        ge       = (shifted >= {1'b0, in_den});
        rem_next = ge ? trial[VW-1:0] : shifted[VW-1:0];
        dq_next  = {in_dq[PW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
            den_reg  <= in_den;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_dq    = dq_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;

endmodule

// ===== hw/rtl/divider_resistance_measure.sv =====
// Top level of the divider resistance measurement block.
// Depends on drm_pkg and drm_div_cell.
// Throughput is one request per cycle; the whole pipeline holds while a result waits.
// The chain of division cells, one quotient bit per cell, makes up most of the pipeline depth.
// Synchronous active-low reset clears all pipeline valid bits and all configuration registers.
module divider_resistance_measure
    import drm_pkg::*;
#(
    parameter int VOLTAGE_WIDTH = 24,
    parameter int OHMS_WIDTH    = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [CFG_DATA_W-1:0]                 cfg_wdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // reference_uv, node_uv, rail_uv
    input  logic [((3*VOLTAGE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // resistance_milliohms, error_code, result_valid, open_flag, short_flag,
    // numerator_uv, denominator_uv
    output logic [OUT_TDATA_W-1:0]                m_axis_tdata
);

    localparam int VW = VOLTAGE_WIDTH;
    localparam int NW = VW + 1;
    localparam int MW = OHMS_WIDTH + MILLI_W;
    localparam int PW = MW + VW;
    localparam int H  = VW / 2;
    localparam int WW = (PW > 64) ? PW : 64;
    localparam int RW = PW + 2;
    localparam int SW = CODE_W + 2 * NW + 1;

    logic advance;

    // Configuration; the resistance settings are stored already scaled to milliohms.
    logic [MW-1:0]        refm_reg, minm_reg, maxm_reg, shortm_reg;
    logic signed [VW-1:0] open_reg;
    logic signed [31:0]   off_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refm_reg   <= '0;
            minm_reg   <= '0;
            maxm_reg   <= '0;
            shortm_reg <= '0;
            open_reg   <= '0;
            off_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_REFERENCE_OHMS:   refm_reg   <= MW'(cfg_wdata[OHMS_WIDTH-1:0]) *
                                                    MW'(MILLI_PER_UNIT);
                REG_MINIMUM_OHMS:     minm_reg   <= MW'(cfg_wdata[OHMS_WIDTH-1:0]) *
                                                    MW'(MILLI_PER_UNIT);
                REG_MAXIMUM_OHMS:     maxm_reg   <= MW'(cfg_wdata[OHMS_WIDTH-1:0]) *
                                                    MW'(MILLI_PER_UNIT);
                REG_SHORT_LIMIT_OHMS: shortm_reg <= MW'(cfg_wdata[OHMS_WIDTH-1:0]) *
                                                    MW'(MILLI_PER_UNIT);
                REG_OPEN_LIMIT_UV:    open_reg   <= cfg_wdata[VW-1:0];
                REG_PATH_OFFSET:      off_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 0: differences and early classification.
    logic signed [VW-1:0] in_ref, in_node, in_rail;
    logic signed [NW-1:0] num_c, den_c;
    logic                 bad_c;
    logic [CODE_W-1:0]    code_c;

    always_comb begin
        in_ref  = s_axis_tdata[VW-1:0];
        in_node = s_axis_tdata[2*VW-1:VW];
        in_rail = s_axis_tdata[3*VW-1:2*VW];
        num_c   = NW'(in_ref) - NW'(in_node);
        den_c   = NW'(in_node) - NW'(in_rail);
        bad_c   = (refm_reg == '0) || (maxm_reg == '0) || (minm_reg > maxm_reg) ||
                  (in_ref <= in_rail);
        if (bad_c) begin
            code_c = ERR_REFERENCE;
            num_c  = '0;
            den_c  = '0;
        end else if ((den_c <= NW'(open_reg)) || (den_c == '0)) begin
            code_c = ERR_OPEN;
        end else if (num_c[NW-1] || den_c[NW-1]) begin
            code_c = ERR_NEGATIVE;
        end else begin
            code_c = ERR_NONE;
        end
    end

    logic                 s0_v_reg, s1_v_reg, s2_v_reg;
    logic [CODE_W-1:0]    s0_code_reg, s1_code_reg, s2_code_reg;
    logic signed [NW-1:0] s0_num_reg, s1_num_reg, s2_num_reg;
    logic signed [NW-1:0] s0_den_reg, s1_den_reg, s2_den_reg;
    logic [MW+H-1:0]      s1_lo_reg;
    logic [MW+VW-H-1:0]   s1_hi_reg;
    logic [PW-1:0]        s2_prod_reg, prod_c;
    logic                 s2_ovf_reg;
    logic [WW-1:0]        prod_wide;

    always_comb begin
        prod_c    = PW'(s1_lo_reg) + (PW'(s1_hi_reg) << H);
        prod_wide = WW'(prod_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else if (advance) begin
            s0_v_reg <= s_axis_tvalid;
            s1_v_reg <= s0_v_reg;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s0_code_reg <= code_c;
            s0_num_reg  <= num_c;
            s0_den_reg  <= den_c;
            s1_code_reg <= s0_code_reg;
            s1_num_reg  <= s0_num_reg;
            s1_den_reg  <= s0_den_reg;
            s1_lo_reg   <= (MW+H)'(refm_reg) * (MW+H)'(s0_num_reg[H-1:0]);
            s1_hi_reg   <= (MW+VW-H)'(refm_reg) * (MW+VW-H)'(s0_num_reg[VW-1:H]);
            s2_code_reg <= s1_code_reg;
            s2_num_reg  <= s1_num_reg;
            s2_den_reg  <= s1_den_reg;
            s2_prod_reg <= prod_c;
            s2_ovf_reg  <= (prod_wide > WW'(64'h7FFF_FFFF_FFFF_FFFF));
        end
    end

    // Division chain.
    logic          c_valid [0:PW];
    logic [VW-1:0] c_rem   [0:PW];
    logic [PW-1:0] c_dq    [0:PW];
    logic [VW-1:0] c_den   [0:PW];
    logic [SW-1:0] c_side  [0:PW];

    assign c_valid[0] = s2_v_reg;
    assign c_rem[0]   = '0;
    assign c_dq[0]    = s2_prod_reg;
    assign c_den[0]   = s2_den_reg[VW-1:0];
    assign c_side[0]  = {s2_ovf_reg, s2_den_reg, s2_num_reg, s2_code_reg};

    for (genvar i = 0; i < PW; i++) begin : g_cell
        drm_div_cell #(
            .VW(VW),
            .PW(PW),
            .SW(SW)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (advance),
            .in_valid (c_valid[i]),
            .in_rem   (c_rem[i]),
            .in_dq    (c_dq[i]),
            .in_den   (c_den[i]),
            .in_side  (c_side[i]),
            .out_valid(c_valid[i+1]),
            .out_rem  (c_rem[i+1]),
            .out_dq   (c_dq[i+1]),
            .out_den  (c_den[i+1]),
            .out_side (c_side[i+1])
        );
    end

    // Post stage 1: overflow and negative-result checks and offset subtraction.
    logic [CODE_W-1:0]    d_code;
    logic signed [NW-1:0] d_num, d_den;
    logic                 d_ovf;
    logic [PW-1:0]        d_q;
    logic [CODE_W-1:0]    p1_code_c;

    always_comb begin
        d_code = c_side[PW][CODE_W-1:0];
        d_num  = c_side[PW][CODE_W+NW-1:CODE_W];
        d_den  = c_side[PW][CODE_W+2*NW-1:CODE_W+NW];
        d_ovf  = c_side[PW][SW-1];
        d_q    = c_dq[PW];
        if (d_code != ERR_NONE) begin
            p1_code_c = d_code;
        end else if (d_ovf) begin
            p1_code_c = ERR_OVERFLOW;
        end else if (!off_reg[31] && (off_reg != '0) && (d_q < PW'(off_reg))) begin
            p1_code_c = ERR_NEGATIVE;
        end else begin
            p1_code_c = ERR_NONE;
        end
    end

    logic                 p1_v_reg;
    logic [CODE_W-1:0]    p1_code_reg;
    logic signed [NW-1:0] p1_num_reg, p1_den_reg;
    logic signed [RW-1:0] p1_r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
        end else if (advance) begin
            p1_v_reg <= c_valid[PW];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_code_reg <= p1_code_c;
            p1_num_reg  <= d_num;
            p1_den_reg  <= d_den;
            p1_r_reg    <= $signed({2'b00, d_q}) - RW'(off_reg);
        end
    end

    // Post stage 2: range classification into the output register.
    logic [CODE_W-1:0]    fin_code;
    logic signed [63:0]   num_wide, den_wide;
    logic [RES_W-1:0]     res_c;
    logic [OUT_TDATA_W-1:0] out_c;

    always_comb begin
        fin_code = p1_code_reg;
        if (p1_code_reg == ERR_NONE) begin
            if ((p1_r_reg <= $signed(RW'(shortm_reg))) ||
                (p1_r_reg < $signed(RW'(minm_reg)))) begin
                fin_code = ERR_SHORT;
            end else if (p1_r_reg > $signed(RW'(maxm_reg))) begin
                fin_code = ERR_RANGE;
            end
        end
        num_wide = 64'(p1_num_reg);
        den_wide = 64'(p1_den_reg);
        res_c    = (fin_code == ERR_NONE) ? p1_r_reg[RES_W-1:0] : '0;
        out_c    = '0;
        out_c[RES_W-1:0]                 = res_c;
        out_c[RES_W+CODE_W-1:RES_W]      = fin_code;
        out_c[RES_W+CODE_W]              = (fin_code == ERR_NONE);
        out_c[RES_W+CODE_W+1]            = (fin_code == ERR_OPEN);
        out_c[RES_W+CODE_W+2]            = (fin_code == ERR_SHORT);
        out_c[RES_W+CODE_W+3 +: VOLT_OUT_W]              = num_wide[VOLT_OUT_W-1:0];
        out_c[RES_W+CODE_W+3+VOLT_OUT_W +: VOLT_OUT_W]   = den_wide[VOLT_OUT_W-1:0];
    end

    logic                   out_v_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    assign advance = !out_v_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (advance) begin
            out_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_c;
        end
    end

    assign s_axis_tready = advance;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== test/divider_resistance_measure_test.sv =====
// Testbench for divider_resistance_measure: drives voltage requests, predicts each result
// in SystemVerilog and compares every field of each result. Depends on drm_pkg and the RTL.
`timescale 1ns / 100ps

module divider_resistance_measure_test;
    import drm_pkg::*;

    localparam int VW = 24;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic [VOLT_OUT_W-1:0] denominator_uv;
        logic [VOLT_OUT_W-1:0] numerator_uv;
        logic                  short_flag;
        logic                  open_flag;
        logic                  result_valid;
        logic [CODE_W-1:0]     error_code;
        logic [RES_W-1:0]      resistance_milliohms;
    } result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    divider_resistance_measure i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    longint ref_ohms, min_ohms, max_ohms, short_ohms, open_limit, path_offset;
    result_t expected_results[$];
    int send_idle_pct = 0, recv_idle_pct = 0;
    int mismatches = 0, results_seen = 0, requests_sent = 0;
    int code_hits [8];
    int cycles = 0;

    function automatic result_t predict_cell(longint vref, longint vnode, longint vrail);
        result_t r;
        longint num, den, refm, res;
        logic [CODE_W-1:0] code;
        num = 0; den = 0; res = 0;
        r = '0;
        if (ref_ohms == 0 || max_ohms == 0 || min_ohms > max_ohms || vref <= vrail) begin
            code = ERR_REFERENCE;
        end else begin
            num = vref - vnode;
            den = vnode - vrail;
            if (den <= open_limit || den == 0) begin
                code = ERR_OPEN;
            end else if (num < 0 || den < 0) begin
                code = ERR_NEGATIVE;
            end else begin
                refm = ref_ohms * 1000;
                res = (refm * num) / den;
                if (path_offset > 0 && res < path_offset) begin
                    code = ERR_NEGATIVE;
                    res = 0;
                end else begin
                    res = res - path_offset;
                    if (res <= short_ohms * 1000 || res < min_ohms * 1000) code = ERR_SHORT;
                    else if (res > max_ohms * 1000) code = ERR_RANGE;
                    else code = ERR_NONE;
                    if (code != ERR_NONE) res = 0;
                end
            end
        end
        r.resistance_milliohms = res[RES_W-1:0];
        r.error_code = code;
        r.result_valid = (code == ERR_NONE);
        r.open_flag = (code == ERR_OPEN);
        r.short_flag = (code == ERR_SHORT);
        r.numerator_uv = num[VOLT_OUT_W-1:0];
        r.denominator_uv = den[VOLT_OUT_W-1:0];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[31:0];
        case (idx)
            REG_REFERENCE_OHMS:   ref_ohms = value & 64'hFFFFFF;
            REG_MINIMUM_OHMS:     min_ohms = value & 64'hFFFFFF;
            REG_MAXIMUM_OHMS:     max_ohms = value & 64'hFFFFFF;
            REG_SHORT_LIMIT_OHMS: short_ohms = value & 64'hFFFFFF;
            REG_OPEN_LIMIT_UV:    open_limit = longint'(signed'(value[VW-1:0]));
            REG_PATH_OFFSET:      path_offset = longint'(signed'(value[31:0]));
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(longint rohm, longint mn, longint mx, longint sh, longint ol,
                             longint off);
        write_reg(REG_REFERENCE_OHMS, rohm);
        write_reg(REG_MINIMUM_OHMS, mn);
        write_reg(REG_MAXIMUM_OHMS, mx);
        write_reg(REG_SHORT_LIMIT_OHMS, sh);
        write_reg(REG_OPEN_LIMIT_UV, ol);
        write_reg(REG_PATH_OFFSET, off);
    endtask

    task automatic drain;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    // Sends one request; tvalid stays high across back-to-back requests unless the random send idle drops it.
    task automatic send_cell(longint vref, longint vnode, longint vrail);
        logic [VW-1:0] a, b, c;
        a = vref[VW-1:0];
        b = vnode[VW-1:0];
        c = vrail[VW-1:0];
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c, b, a};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_results.push_back(predict_cell(longint'(signed'(a)), longint'(signed'(b)),
                                                longint'(signed'(c))));
        requests_sent++;
    endtask

    task automatic stop_sending;
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic longint rand_volt(longint lo, longint hi);
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            result_t got, want;
            got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("Unexpected result %h", got);
            end else begin
                want = expected_results.pop_front();
                code_hits[want.error_code] = code_hits[want.error_code] + 1;
                if (got !== want) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("Mismatch: exp res=%0d code=%0d v=%b o=%b s=%b num=%h den=%h; got res=%0d code=%0d v=%b o=%b s=%b num=%h den=%h",
                            want.resistance_milliohms, want.error_code, want.result_valid,
                            want.open_flag, want.short_flag, want.numerator_uv,
                            want.denominator_uv, got.resistance_milliohms, got.error_code,
                            got.result_valid, got.open_flag, got.short_flag,
                            got.numerator_uv, got.denominator_uv);
                end
            end
        end
        if (cycles > MAX_CYCLES) begin
            $display("Timeout waiting for results.");
            $display("** divider_resistance_measure: FAILED **");
            $finish;
        end
    end

    task automatic test_reset_config;
        // All registers are zero after reset, so every request reports bad configuration.
        ref_ohms = 0; min_ohms = 0; max_ohms = 0; short_ohms = 0; open_limit = 0;
        path_offset = 0;
        send_cell(1000, 500, 0);
        send_cell(-8388608, 8388607, 8388607);
        stop_sending();
        drain();
    endtask

    task automatic test_directed;
        configure(1000, 10, 100000, 5, 0, 0);
        send_cell(8388607, 0, -8388608);
        send_cell(-8388608, 0, 8388607);
        send_cell(100, 100, 100);
        send_cell(1000, 0, 0);
        send_cell(1000, 500, 0);
        send_cell(1000, 1200, 0);
        send_cell(1000, 999, 0);
        send_cell(1000, 1, 0);
        send_cell(8388607, 8388606, -8388608);
        send_cell(8388607, -8388607, -8388608);
        send_cell(0, -5000, -10000);
        stop_sending();
        drain();
        configure(16777215, 0, 16777215, 0, -8388608, 2147483647);
        send_cell(8388607, -8388607, -8388608);
        send_cell(1000, 500, 0);
        stop_sending();
        drain();
        configure(16777215, 0, 16777215, 0, 8388607, -2147483648);
        send_cell(8388607, -8388607, -8388608);
        send_cell(1000, 500, 0);
        stop_sending();
        drain();
        configure(500, 600, 400, 0, 0, 0);
        send_cell(1000, 500, 0);
        stop_sending();
        drain();
        configure(1000, 1000, 1000, 999, 10, 100);
        send_cell(2000, 1000, 0);
        send_cell(2001, 1000, 0);
        send_cell(1000, 5, 0);
        stop_sending();
        drain();
    endtask

    task automatic run_random(int count, int sidle, int ridle);
        longint r, n, l;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0, 1: begin
                    r = rand_volt(-8388608, 8388607);
                    n = rand_volt(-8388608, 8388607);
                    l = rand_volt(-8388608, 8388607);
                end
                2: begin
                    l = -8388608;
                    r = 8388607;
                    n = rand_volt(-8388608, 8388607);
                end
                default: begin
                    // Well-formed divider: rail at or below node, node at or below reference.
                    l = rand_volt(-8388608, 0);
                    n = l + rand_volt(0, 100000);
                    r = n + rand_volt(0, 100000);
                    if (r > 8388607) r = 8388607;
                    if (n > 8388607) n = 8388607;
                end
            endcase
            send_cell(r, n, l);
        end
        stop_sending();
        drain();
        recv_idle_pct = 0;
    endtask

    task automatic test_random_settings;
        configure(1000, 100, 5000, 50, 10, 0);
        run_random(480, 23, 70);
        configure(10, 1, 100, 0, -100, -500);
        run_random(480, 70, 23);
        configure(16777215, 1000, 10000000, 1, 0, 1000);
        run_random(480, 0, 0);
    endtask

    initial begin
        for (int i = 0; i < 8; i++) code_hits[i] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_config();
        test_directed();
        test_random_settings();
        $display("Sent %0d requests, checked %0d results, %0d mismatches.",
                 requests_sent, results_seen, mismatches);
        $display("Codes: none %0d ref %0d open %0d neg %0d short %0d range %0d",
                 code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[5],
                 code_hits[6]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("** divider_resistance_measure: PASSED **");
        else
            $display("** divider_resistance_measure: FAILED **");
        $finish;
    end

endmodule
